>>> rtl/bhash_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte hash package
// Algorithm codes and the start values and constants of the four hashes.
// ----------------------------------------------------------------------------
package bhash_pkg;

	typedef enum logic [1:0] {
		ALG_FNV1A32 = 2'd0,
		ALG_FNV1A64 = 2'd1,
		ALG_CRC16   = 2'd2,
		ALG_CRC32   = 2'd3
	} alg_t;

	localparam logic [63:0] FNV32_BASIS = 64'h0000_0000_811C_9DC5;
	localparam logic [63:0] FNV64_BASIS = 64'hCBF2_9CE4_8422_2325;
	localparam logic [63:0] CRC16_INIT  = 64'h0000_0000_0000_FFFF;
	localparam logic [63:0] CRC32_INIT  = 64'h0000_0000_FFFF_FFFF;
	localparam logic [31:0] CRC32_POLY  = 32'hEDB8_8320;
	localparam logic [31:0] FNV32_LOW   = 32'h0000_0193;
	localparam logic [63:0] FNV64_LOW   = 64'h0000_0000_0000_01B3;

endpackage

>>> rtl/multi_algorithm_byte_hash_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-algorithm byte hash core
// Hashes a byte stream with FNV-1a 32, FNV-1a 64, CRC-16/CCITT-FALSE or
// CRC-32 and delivers the digest, zero-extended to 64 bits.
// ----------------------------------------------------------------------------
// The core takes one byte per clock cycle unless in_stall is high, which
// happens while a last byte or empty-message flag waits in the entry stage
// for the held output register. That item then passes from the entry stage
// into the output register, where the digest becomes valid. Bytes are
// registered on entry and the absorb logic updates the running value.
// Select the algorithm through the configuration register between messages.
module multi_algorithm_byte_hash_core
	import bhash_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        algorithm_select_we,
	input  logic [1:0]  algorithm_select,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        empty_flag,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] digest
);

	alg_t        alg_sel_q;
	logic        running_valid_s1;
	alg_t        alg_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        empty_s1;
	logic [63:0] running_q;
	logic        in_msg_q;
	logic [63:0] next_value;
	logic [63:0] final_value;
	logic        out_free;
	logic        emits_s1;
	logic        adv_s1;
	logic        accept;

	assign emits_s1 = empty_s1 || last_s1;
	assign adv_s1   = running_valid_s1 && (!emits_s1 || out_free);
	assign in_stall = running_valid_s1 && !adv_s1;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alg_sel_q <= ALG_FNV1A32;
		end else if (algorithm_select_we) begin
			alg_sel_q <= alg_t'(algorithm_select);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_valid_s1 <= 1'b0;
		end else if (accept) begin
			running_valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			running_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			alg_s1   <= alg_sel_q;
			byte_s1  <= data_byte;
			last_s1  <= last_byte;
			empty_s1 <= empty_flag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 64'h0;
			in_msg_q  <= 1'b0;
		end else if (adv_s1) begin
			if (emits_s1) begin
				running_q <= 64'h0;
				in_msg_q  <= 1'b0;
			end else begin
				running_q <= next_value;
				in_msg_q  <= 1'b1;
			end
		end
	end

	bhash_absorb u_absorb (
		.alg         (alg_s1),
		.in_msg      (in_msg_q),
		.running     (running_q),
		.data_byte   (byte_s1),
		.next_value  (next_value),
		.final_value (final_value)
	);

	bhash_out_reg u_out_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (adv_s1 && emits_s1),
		.load_digest (empty_s1 ? 64'h0 : final_value),
		.free        (out_free),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.digest      (digest)
	);

`ifndef SYNTHESIS
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> running_valid_s1)
		else $error("Input stalled with no item in the entry stage.");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && emits_s1 |=> out_valid)
		else $error("Finished message did not reach the output register.");

	a_message_closed: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && emits_s1 |=> !in_msg_q && running_q == 64'h0)
		else $error("Message state not cleared after the digest.");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && empty_s1 |=> digest == 64'h0)
		else $error("Empty message gave a nonzero digest.");
`endif

endmodule

>>> rtl/bhash_absorb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte hash absorb logic
// Selects the start value, folds one byte into the running value and forms
// the finished digest of the selected algorithm.
// ----------------------------------------------------------------------------
module bhash_absorb
	import bhash_pkg::*;
(
	input  alg_t        alg,
	input  logic        in_msg,
	input  logic [63:0] running,
	input  logic [7:0]  data_byte,
	output logic [63:0] next_value,
	output logic [63:0] final_value
);

	function automatic logic [31:0] crc32_byte(input logic [31:0] r_in);
		logic [31:0] r;
		r = r_in;
		for (int k = 0; k < 8; k++) begin
			r = (r >> 1) ^ (r[0] ? CRC32_POLY : 32'h0);
		end
		return r;
	endfunction

	logic [63:0] v;
	logic [63:0] vx;
	logic [31:0] x32;
	logic [15:0] c16;
	logic [7:0]  t;
	logic [15:0] crc16_next;

	always_comb begin
		unique case (alg)
			ALG_FNV1A32: v = in_msg ? running : FNV32_BASIS;
			ALG_FNV1A64: v = in_msg ? running : FNV64_BASIS;
			ALG_CRC16:   v = in_msg ? running : CRC16_INIT;
			ALG_CRC32:   v = in_msg ? running : CRC32_INIT;
			default:     v = running;
		endcase
	end

	assign vx  = v ^ {56'h0, data_byte};
	assign x32 = vx[31:0];
	assign c16 = v[15:0];

	always_comb begin
		t = c16[15:8] ^ data_byte;
		t = t ^ (t >> 4);
		crc16_next = (c16 << 8) ^ ({8'h0, t} << 12) ^ ({8'h0, t} << 5) ^ {8'h0, t};
	end

	always_comb begin
		unique case (alg)
			ALG_FNV1A32: next_value = {32'h0, (x32 << 24) + x32 * FNV32_LOW};
			ALG_FNV1A64: next_value = (vx << 40) + vx * FNV64_LOW;
			ALG_CRC16:   next_value = {48'h0, crc16_next};
			ALG_CRC32:   next_value = {32'h0, crc32_byte(x32)};
			default:     next_value = 64'h0;
		endcase
	end

	always_comb begin
		unique case (alg)
			ALG_FNV1A32: final_value = {32'h0, next_value[31:0]};
			ALG_FNV1A64: final_value = next_value;
			ALG_CRC16:   final_value = {48'h0, next_value[15:0]};
			ALG_CRC32:   final_value = {32'h0, next_value[31:0] ^ CRC32_INIT[31:0]};
			default:     final_value = 64'h0;
		endcase
	end

endmodule

>>> rtl/bhash_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte hash output register
// Holds one digest until the downstream side takes the transaction.
// ----------------------------------------------------------------------------
module bhash_out_reg
	import bhash_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic [63:0] load_digest,
	output logic        free,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] digest
);

	logic        valid_q;
	logic [63:0] digest_q;

	assign free      = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign digest    = digest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			digest_q <= load_digest;
		end
	end

endmodule
